/* src/scc_pkg.sv */
// Shared types, widths and register indexes for the segment/square collision unit.
// No dependencies; imported by every other file in src.
`default_nettype none

package scc_pkg;

    // Coordinate width of the ports (signed, 4 fractional bits).
    localparam int COORD_BITS = 16;
    // Side length width (unsigned).
    localparam int SIDE_BITS = COORD_BITS - 1;
    // A point in 1/32 units (one extra fractional bit).
    localparam int PT_BITS = COORD_BITS + 1;
    // Segment direction in 1/32 units.
    localparam int DIR_BITS = COORD_BITS + 2;
    // Offset between segment start and an edge start, corner math included.
    localparam int OFS_BITS = COORD_BITS + 3;
    // Common width of numerators and denominators.
    localparam int WIDE_BITS = DIR_BITS + OFS_BITS + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CTR_X       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CTR_Y       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE_LENGTH = 2'd2;

    // Stage 1 result: direction, offsets to the corners, full side length.
    typedef struct packed {
        logic signed [DIR_BITS-1:0] d1x;
        logic signed [DIR_BITS-1:0] d1y;
        logic signed [OFS_BITS-1:0] oxl;
        logic signed [OFS_BITS-1:0] oxr;
        logic signed [OFS_BITS-1:0] oyt;
        logic signed [OFS_BITS-1:0] oyb;
        logic        [COORD_BITS-1:0] side2;
    } geo_t;

    // Stage 2 result: raw products.
    typedef struct packed {
        logic signed [WIDE_BITS-1:0] p_xt;
        logic signed [WIDE_BITS-1:0] p_xb;
        logic signed [WIDE_BITS-1:0] p_yl;
        logic signed [WIDE_BITS-1:0] p_yr;
        logic signed [WIDE_BITS-1:0] den_h;
        logic signed [WIDE_BITS-1:0] den_v;
        logic signed [WIDE_BITS-1:0] tn_t;
        logic signed [WIDE_BITS-1:0] tn_l;
        logic signed [WIDE_BITS-1:0] tn_r;
        logic signed [WIDE_BITS-1:0] tn_b;
    } prod_t;

    // Stage 3 result: numerators and denominators per edge.
    typedef struct packed {
        logic signed [WIDE_BITS-1:0] sn_tl;
        logic signed [WIDE_BITS-1:0] sn_r;
        logic signed [WIDE_BITS-1:0] sn_b;
        logic signed [WIDE_BITS-1:0] den_h;
        logic signed [WIDE_BITS-1:0] den_v;
        logic signed [WIDE_BITS-1:0] tn_t;
        logic signed [WIDE_BITS-1:0] tn_l;
        logic signed [WIDE_BITS-1:0] tn_r;
        logic signed [WIDE_BITS-1:0] tn_b;
    } frac_t;

    // num/den in [0,1], den nonzero
    function automatic logic in_unit(
        input logic signed [WIDE_BITS-1:0] num,
        input logic signed [WIDE_BITS-1:0] den
    );
        logic res;
        if (den > 0)
        begin
            res = (num >= 0) && (num <= den);
        end
        else
        begin
            res = (num <= 0) && (num >= den);
        end
        return res;
    endfunction

    // one edge: parallel lines never hit
    function automatic logic edge_hit(
        input logic signed [WIDE_BITS-1:0] sn,
        input logic signed [WIDE_BITS-1:0] tn,
        input logic signed [WIDE_BITS-1:0] den
    );
        return (den != 0) && in_unit(sn, den) && in_unit(tn, den);
    endfunction

endpackage

`default_nettype wire

/* src/segment_square_collision_unit.sv */
// Top level of the segment/square collision unit: config registers, pipeline control.
// Depends on scc_pkg, scc_front, scc_products, scc_decide.
`default_nettype none

// Usage
//   Input channel: in_valid/in_stall carry one segment (start_x, start_y,
//   end_x, end_y; signed, 4 fractional bits) per transaction.
//   Output channel: out_valid/out_stall carry the hit flag, one per segment,
//   in input order.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 center x,
//   1 center y, 2 side length) and cfg_data; cfg_ready is always high and
//   an unknown index is dropped. Write only while the pipeline is empty.
// Timing
//   Four register stages: corner offsets, products, numerators, range check.
//   A segment accepted at the input passes through them in that order, and its
//   result is offered on out_valid once it reaches the last stage. One segment
//   per cycle is sustained while out_stall is low.
// Stall
//   Each stage loads when it is empty or the stage after it moves, so a stall
//   at the output first fills the bubbles; in_stall rises only once all four
//   stages hold a result and out_stall is high.
// Reset
//   rst_n clears all stage valid bits and the config registers (all zero).
module segment_square_collision_unit
    import scc_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              hit,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic        [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic        [COORD_BITS-1:0] cfg_data
);

    // configuration
    logic signed [COORD_BITS-1:0] ctr_x_reg;
    logic signed [COORD_BITS-1:0] ctr_y_reg;
    logic        [SIDE_BITS-1:0]  side_length_reg;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    // per stage: may load this cycle
    logic rdy1, rdy2, rdy3, rdy4;

    geo_t  geo;
    frac_t frac;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_x_reg       <= '0;
            ctr_y_reg       <= '0;
            side_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CTR_X:       ctr_x_reg       <= signed'(cfg_data);
                CFG_CTR_Y:       ctr_y_reg       <= signed'(cfg_data);
                CFG_SIDE_LENGTH: side_length_reg <= cfg_data[SIDE_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // ready ripples back from the output; bubbles get squeezed out
    always_comb
    begin
        rdy4 = !v4_reg || !out_stall;
        rdy3 = !v3_reg || rdy4;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;

        v1_next = rdy1 ? in_valid : v1_reg;
        v2_next = rdy2 ? v1_reg   : v2_reg;
        v3_next = rdy3 ? v2_reg   : v3_reg;
        v4_next = rdy4 ? v3_reg   : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign in_stall  = !rdy1;
    assign out_valid = v4_reg;

    scc_front u_front (
        .clk         (clk),
        .load        (rdy1),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .ctr_x       (ctr_x_reg),
        .ctr_y       (ctr_y_reg),
        .side_length (side_length_reg),
        .geo         (geo)
    );

    scc_products u_products (
        .clk      (clk),
        .load_mul (rdy2),
        .load_sum (rdy3),
        .geo      (geo),
        .frac     (frac)
    );

    scc_decide u_decide (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (rdy4),
        .frac  (frac),
        .hit   (hit)
    );

    // input only backs up when the whole pipe is full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // a transaction in the last stage that is not taken must not vanish
    assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && v4_reg && out_stall) |=> (v3_reg && v4_reg))
        else $error("stalled result dropped from the pipeline");

    // a stalled result keeps its flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(hit)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

/* src/scc_front.sv */
// Stage 1: segment direction and offsets to the square's corners, 1/32 units.
// Depends on scc_pkg.
`default_nettype none

module scc_front
    import scc_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         load,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    input  wire logic signed [COORD_BITS-1:0] ctr_x,
    input  wire logic signed [COORD_BITS-1:0] ctr_y,
    input  wire logic        [SIDE_BITS-1:0]  side_length,
    output geo_t                              geo
);

    geo_t geo_reg;
    geo_t geo_next;

    logic signed [OFS_BITS-1:0] sx_w;
    logic signed [OFS_BITS-1:0] sy_w;
    logic signed [OFS_BITS-1:0] ex_w;
    logic signed [OFS_BITS-1:0] ey_w;
    logic signed [OFS_BITS-1:0] cx_w;
    logic signed [OFS_BITS-1:0] cy_w;
    logic signed [OFS_BITS-1:0] h_w;

    always_comb
    begin
        sx_w = OFS_BITS'(signed'({start_x, 1'b0}));
        sy_w = OFS_BITS'(signed'({start_y, 1'b0}));
        ex_w = OFS_BITS'(signed'({end_x, 1'b0}));
        ey_w = OFS_BITS'(signed'({end_y, 1'b0}));
        cx_w = OFS_BITS'(signed'({ctr_x, 1'b0}));
        cy_w = OFS_BITS'(signed'({ctr_y, 1'b0}));
        h_w  = signed'(OFS_BITS'(side_length));

        geo_next.d1x   = DIR_BITS'(ex_w - sx_w);
        geo_next.d1y   = DIR_BITS'(ey_w - sy_w);
        // left edge at cx - h, right at cx + h, top at cy + h, bottom at cy - h
        geo_next.oxl   = sx_w - cx_w + h_w;
        geo_next.oxr   = sx_w - cx_w - h_w;
        geo_next.oyt   = sy_w - cy_w - h_w;
        geo_next.oyb   = sy_w - cy_w + h_w;
        geo_next.side2 = {side_length, 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            geo_reg <= geo_next;
        end
    end

    assign geo = geo_reg;

endmodule

`default_nettype wire

/* src/scc_products.sv */
// Stages 2 and 3: cross products, then numerators per edge.
// Depends on scc_pkg.
`default_nettype none

module scc_products
    import scc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  load_mul,
    input  wire logic  load_sum,
    input  wire geo_t  geo,
    output frac_t      frac
);

    prod_t prod_reg;
    prod_t prod_next;
    frac_t frac_reg;
    frac_t frac_next;

    logic signed [COORD_BITS:0] hs;

    always_comb
    begin
        hs = signed'({1'b0, geo.side2});
        // operands sign-extended first so the products keep every bit
        prod_next.p_xt  = WIDE_BITS'(geo.d1x) * WIDE_BITS'(geo.oyt);
        prod_next.p_xb  = WIDE_BITS'(geo.d1x) * WIDE_BITS'(geo.oyb);
        prod_next.p_yl  = WIDE_BITS'(geo.d1y) * WIDE_BITS'(geo.oxl);
        prod_next.p_yr  = WIDE_BITS'(geo.d1y) * WIDE_BITS'(geo.oxr);
        // horizontal edges have d2 = (2h, 0), vertical ones d2 = (0, -2h)
        prod_next.den_h = -(WIDE_BITS'(hs) * WIDE_BITS'(geo.d1y));
        prod_next.den_v = -(WIDE_BITS'(hs) * WIDE_BITS'(geo.d1x));
        prod_next.tn_t  = WIDE_BITS'(hs) * WIDE_BITS'(geo.oyt);
        prod_next.tn_l  = WIDE_BITS'(hs) * WIDE_BITS'(geo.oxl);
        prod_next.tn_r  = WIDE_BITS'(hs) * WIDE_BITS'(geo.oxr);
        prod_next.tn_b  = WIDE_BITS'(hs) * WIDE_BITS'(geo.oyb);
    end

    always_comb
    begin
        // top and left edges share their start corner
        frac_next.sn_tl = prod_reg.p_xt - prod_reg.p_yl;
        frac_next.sn_r  = prod_reg.p_xt - prod_reg.p_yr;
        frac_next.sn_b  = prod_reg.p_xb - prod_reg.p_yl;
        frac_next.den_h = prod_reg.den_h;
        frac_next.den_v = prod_reg.den_v;
        frac_next.tn_t  = prod_reg.tn_t;
        frac_next.tn_l  = prod_reg.tn_l;
        frac_next.tn_r  = prod_reg.tn_r;
        frac_next.tn_b  = prod_reg.tn_b;
    end

    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            prod_reg <= prod_next;
        end
        if (load_sum)
        begin
            frac_reg <= frac_next;
        end
    end

    assign frac = frac_reg;

endmodule

`default_nettype wire

/* src/scc_decide.sv */
// Stage 4: range checks of s and t for each edge of the square, registered hit flag.
// Depends on scc_pkg.
`default_nettype none

module scc_decide
    import scc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  wire frac_t frac,
    output logic       hit
);

    logic hit_reg;
    logic hit_next;

    always_comb
    begin
        hit_next = edge_hit(frac.sn_tl, frac.tn_t, frac.den_h)
                 | edge_hit(frac.sn_tl, frac.tn_l, frac.den_v)
                 | edge_hit(frac.sn_r,  frac.tn_r, frac.den_v)
                 | edge_hit(frac.sn_b,  frac.tn_b, frac.den_h);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

    // degenerate segment or zero side: every edge is parallel, no hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && frac.den_h == 0 && frac.den_v == 0) |=> !hit_reg)
        else $error("hit set with all denominators zero");

endmodule

`default_nettype wire

/* dv/tb_segment_square_collision_unit.sv */
// Self-checking testbench for segment_square_collision_unit: random and directed segments
// against a square obstacle, checked against an in-bench hit predictor.
// Depends on scc_pkg and the RTL under src.

module tb_segment_square_collision_unit
    import scc_pkg::*;
();

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    // Four register stages; the final settle wait scales with that depth.
    localparam int PIPE_LATENCY   = 4;
    localparam int SETTLE_CYCLES  = 4 * PIPE_LATENCY;
    localparam int IDLE_PCT       = 27;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SEGMENTS = 235;
    // One long receiver hold-off, started once this many results were seen.
    localparam int HOLD_AT_RESULT = 400;
    localparam int HOLD_CYCLES    = 80;
    // Window of accepted segments in which neither side idles.
    localparam int CALM_FIRST     = 700;
    localparam int CALM_LAST      = 1000;
    localparam int MAX_REPORTS    = 10;
    localparam int COORD_MAX      = 2 ** (COORD_BITS - 1) - 1;
    localparam int COORD_MIN      = -(2 ** (COORD_BITS - 1));
    // Index past the register list; the block must drop such a write.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct {
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
    } segment_t;

    // DUT ports; every input has a known value from time zero.
    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic signed [COORD_BITS-1:0]    start_x   = '0;
    logic signed [COORD_BITS-1:0]    start_y   = '0;
    logic signed [COORD_BITS-1:0]    end_x     = '0;
    logic signed [COORD_BITS-1:0]    end_y     = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            hit;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic        [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic        [COORD_BITS-1:0]    cfg_data  = '0;

    // Predictor copy of the obstacle registers (reset values).
    logic signed [COORD_BITS-1:0]    obst_cx   = '0;
    logic signed [COORD_BITS-1:0]    obst_cy   = '0;
    logic        [SIDE_BITS-1:0]     obst_side = '0;

    segment_t pending_segments[$];   // filled by the stimulus, drained by the driver
    logic     hit_expected_q[$];     // one predicted flag per accepted segment

    int in_count       = 0;
    int out_count      = 0;
    int cfg_count      = 0;
    int hit_count      = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int hold_left      = 0;
    logic hold_done    = 1'b0;

    always #CLK_HALF clk = ~clk;

    segment_square_collision_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Hit predictor. Everything is in 1/32 units so the corners
    // center +/- side/2 are exact; 64-bit products are wide enough.
    // ------------------------------------------------------------------

    // num/den within [0,1]; den is nonzero
    function automatic logic ratio_in_unit(input longint num, input longint den);
        longint n;
        longint d;
        n = (den < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        return (n >= 0) && (n <= d);
    endfunction

    // Parametric segment/segment test; parallel or collinear never hits.
    function automatic logic edge_crossed(
        input longint p0x, input longint p0y, input longint p1x, input longint p1y,
        input longint q0x, input longint q0y, input longint q1x, input longint q1y
    );
        longint d1x;
        longint d1y;
        longint d2x;
        longint d2y;
        longint ox;
        longint oy;
        longint den;
        d1x = p1x - p0x;
        d1y = p1y - p0y;
        d2x = q1x - q0x;
        d2y = q1y - q0y;
        ox  = p0x - q0x;
        oy  = p0y - q0y;
        den = d1x * d2y - d2x * d1y;
        if (den == 0)
        begin
            return 1'b0;
        end
        return ratio_in_unit(d1x * oy - d1y * ox, den) &&
               ratio_in_unit(d2x * oy - d2y * ox, den);
    endfunction

    function automatic logic predict_hit(input segment_t seg);
        longint sx;
        longint sy;
        longint ex;
        longint ey;
        longint xl;
        longint xr;
        longint yt;
        longint yb;
        sx = 2 * longint'(seg.sx);
        sy = 2 * longint'(seg.sy);
        ex = 2 * longint'(seg.ex);
        ey = 2 * longint'(seg.ey);
        xl = 2 * longint'(obst_cx) - longint'(obst_side);
        xr = 2 * longint'(obst_cx) + longint'(obst_side);
        yt = 2 * longint'(obst_cy) + longint'(obst_side);
        yb = 2 * longint'(obst_cy) - longint'(obst_side);
        // top, left, right, bottom
        return edge_crossed(sx, sy, ex, ey, xl, yt, xr, yt) ||
               edge_crossed(sx, sy, ex, ey, xl, yt, xl, yb) ||
               edge_crossed(sx, sy, ex, ey, xr, yt, xr, yb) ||
               edge_crossed(sx, sy, ex, ey, xl, yb, xr, yb);
    endfunction

    function automatic logic in_calm_window();
        return (in_count >= CALM_FIRST) && (in_count < CALM_LAST);
    endfunction

    // Coordinate near an obstacle edge: often exactly on a corner line,
    // otherwise within a few half-sides of the center, clamped to range.
    function automatic logic signed [COORD_BITS-1:0] near_coord(input int center, input int half);
        int v;
        int span;
        span = 3 * half + 8;
        case ($urandom_range(9))
            0, 1:    v = center - half;
            2, 3:    v = center + half;
            4:       v = center;
            default: v = center + int'($urandom_range(2 * span)) - span;
        endcase
        if (v > COORD_MAX)
        begin
            v = COORD_MAX;
        end
        if (v < COORD_MIN)
        begin
            v = COORD_MIN;
        end
        return v[COORD_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Config tracking: mirror each accepted register write.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            cfg_count++;
            case (cfg_index)
                CFG_CTR_X:       obst_cx   <= cfg_data;
                CFG_CTR_Y:       obst_cy   <= cfg_data;
                CFG_SIDE_LENGTH: obst_side <= cfg_data[SIDE_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Driver: predicts each accepted transaction, then offers the next
    // queued segment unless it idles this cycle. Payload holds while stalled.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_proc
        segment_t seg;
        logic     offer;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                seg.sx = start_x;
                seg.sy = start_y;
                seg.ex = end_x;
                seg.ey = end_y;
                hit_expected_q = {hit_expected_q, predict_hit(seg)};
                in_count++;
            end
            if (!in_valid || !in_stall)
            begin
                offer = (pending_segments.size() != 0) &&
                        (in_calm_window() || ($urandom_range(99) >= IDLE_PCT));
                if (offer)
                begin
                    seg     = pending_segments.pop_front();
                    start_x <= seg.sx;
                    start_y <= seg.sy;
                    end_x   <= seg.ex;
                    end_y   <= seg.ey;
                end
                in_valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random, none in the calm window, plus one long
    // hold-off so the pipeline fills and pushes back on the input.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && (out_count >= HOLD_AT_RESULT))
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !in_calm_window() && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transaction with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_proc
        logic expected_hit;
        if (rst_n && out_valid && !out_stall)
        begin
            out_count++;
            if (hit_expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                begin
                    $display("ERROR: result hit=%b with no segment outstanding", hit);
                end
            end
            else
            begin
                expected_hit = hit_expected_q.pop_front();
                if (expected_hit)
                begin
                    hit_count++;
                end
                if (hit !== expected_hit)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("ERROR: result %0d hit expected %b actual %b",
                                 out_count, expected_hit, hit);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                             quiet_cycles, hit_expected_q.size());
                    $display("segment_square_collision_unit: mismatch");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [COORD_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_obstacle(input logic [COORD_BITS-1:0] cx,
                                input logic [COORD_BITS-1:0] cy,
                                input logic [COORD_BITS-1:0] side_data);
        write_reg(CFG_CTR_X, cx);
        write_reg(CFG_CTR_Y, cy);
        write_reg(CFG_SIDE_LENGTH, side_data);
    endtask

    task automatic push_segment(input logic signed [COORD_BITS-1:0] sx,
                                input logic signed [COORD_BITS-1:0] sy,
                                input logic signed [COORD_BITS-1:0] ex,
                                input logic signed [COORD_BITS-1:0] ey);
        segment_t seg;
        seg.sx = sx;
        seg.sy = sy;
        seg.ex = ex;
        seg.ey = ey;
        pending_segments = {pending_segments, seg};
    endtask

    // Sender pause: nothing queued, nothing offered, every result back.
    // Checked at the falling edge so all clocked updates have landed.
    task automatic wait_drained();
        do
            @(negedge clk);
        while ((pending_segments.size() != 0) || in_valid || (hit_expected_q.size() != 0));
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed phases, then random phases, each phase
    // starting with register writes on an empty pipeline.
    // ------------------------------------------------------------------
    initial
    begin : stimulus_proc
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] a;
        logic signed [COORD_BITS-1:0] b;
        logic        [COORD_BITS-1:0] side_data;
        int half;
        int pick;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Unit-ish square at the origin: edges at +/-16 (1.0 in fixed point).
        set_obstacle(16'sd0, 16'sd0, 16'd32);
        push_segment(-16'sd64, 16'sd0, 16'sd64, 16'sd0);        // straight through
        push_segment(-16'sd8, -16'sd8, 16'sd8, 16'sd8);         // fully inside
        push_segment(16'sd40, 16'sd40, 16'sd80, -16'sd40);      // fully outside
        push_segment(16'sd0, 16'sd0, 16'sd16, 16'sd0);          // end point on right edge
        push_segment(16'sd0, 16'sd0, 16'sd15, 16'sd0);          // one LSB short
        push_segment(16'sd16, 16'sd16, 16'sd32, 16'sd32);       // touches a corner only
        push_segment(-16'sd32, 16'sd16, 16'sd32, 16'sd16);      // collinear with top edge
        push_segment(16'sd20, -16'sd30, 16'sd20, 16'sd30);      // parallel, outside
        push_segment(16'sd16, 16'sd0, 16'sd16, 16'sd0);         // degenerate on an edge
        push_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);   // full-range diagonal
        push_segment(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        push_segment(16'h8000, 16'h8000, 16'h8000, 16'h7FFF);   // far left, vertical
        push_segment(16'sd0, 16'h8000, 16'sd0, 16'h7FFF);       // full-height through
        wait_drained();

        // Zero side: all corners coincide, never a hit. The spare index
        // write must not disturb anything.
        write_reg(CFG_SIDE_LENGTH, 16'd0);
        write_reg(CFG_SPARE_IDX, 16'h5A5A);
        push_segment(-16'sd64, 16'sd0, 16'sd64, 16'sd0);
        push_segment(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        push_segment(-16'sd5, -16'sd7, 16'sd9, 16'sd3);
        wait_drained();

        // Extreme registers; side data has bit 15 set, only 15 bits count.
        set_obstacle(16'h7FFF, 16'h8000, 16'hFFFF);
        push_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        push_segment(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        push_segment(16'sd16383, -16'sd20000, 16'sd16384, -16'sd20000);
        push_segment(16'sd0, 16'sd0, 16'h7FFF, 16'h8000);
        push_segment(16'h8000, 16'h7FFF, 16'h7FFF, -16'sd16385);
        wait_drained();

        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            cx        = COORD_BITS'($urandom);
            cy        = COORD_BITS'($urandom);
            side_data = {1'($urandom), SIDE_BITS'($urandom_range(3000))};
            case (k)
                2:
                begin
                    cx        = COORD_MIN[COORD_BITS-1:0];
                    cy        = COORD_MAX[COORD_BITS-1:0];
                    side_data = 16'h7FFF;
                end
                5:       side_data = {1'b1, SIDE_BITS'(1)};
                7:       side_data = COORD_BITS'($urandom);
                default: ;
            endcase
            set_obstacle(cx, cy, side_data);
            half = int'(side_data[SIDE_BITS-1:0]) / 2;

            // Mostly segments around the obstacle, some axis-aligned ones
            // (parallel edges, degenerate cases), the rest full-range noise.
            for (int n = 0; n < PHASE_SEGMENTS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    push_segment(near_coord(int'(cx), half), near_coord(int'(cy), half),
                                 near_coord(int'(cx), half), near_coord(int'(cy), half));
                end
                else if (pick < 85)
                begin
                    a = near_coord(int'(cx), half);
                    b = near_coord(int'(cy), half);
                    if ($urandom_range(1) == 0)
                    begin
                        push_segment(a, b, a, near_coord(int'(cy), half));
                    end
                    else
                    begin
                        push_segment(a, b, near_coord(int'(cx), half), b);
                    end
                end
                else
                begin
                    push_segment(COORD_BITS'($urandom), COORD_BITS'($urandom),
                                 COORD_BITS'($urandom), COORD_BITS'($urandom));
                end
            end
            wait_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run: %0d segments checked, %0d hits, %0d register writes, %0d mismatches",
                 out_count, hit_count, cfg_count, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("segment_square_collision_unit: match");
        end
        else
        begin
            $display("segment_square_collision_unit: mismatch");
        end
        $finish;
    end

endmodule
